[rtl/core/count_min_sketch_update_assert.svh]
// Assertion macros for the checker file of the sketch block.
`ifndef COUNT_MIN_SKETCH_UPDATE_ASSERT_SVH
`define COUNT_MIN_SKETCH_UPDATE_ASSERT_SVH

// The consequent must hold in the clock after the antecedent.
`define CMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("count_min_sketch_update: check failed");

// The consequent must hold in the same clock as the antecedent.
`define CMS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("count_min_sketch_update: check failed");

`endif

[rtl/core/cms_pkg.sv]
package cms_pkg;

  // Table geometry. Counter (row, column) sits at row * MAX_COLUMNS + column.
  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 4;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int ADDR_W      = ROW_W + COL_W;
  localparam int DEPTH       = MAX_ROWS * MAX_COLUMNS;

  // Field widths.
  localparam int KEY_W       = 32;
  localparam int CNT_W       = 32;
  localparam int ROW_SEL_W   = 2;
  localparam int COL_SEL_W   = 10;
  localparam int COLS_CFG_W  = 11;
  localparam int ROWS_CFG_W  = 3;
  localparam int COEF_W      = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [KEY_W-1:0] HASH_PRIME = 32'hFFFF_FFFB;

  // Remainder unit: DIV_BITS dividend bits retired per cycle.
  localparam int DIV_BITS   = 2;
  localparam int DIV_STEPS  = KEY_W / DIV_BITS;
  localparam int DIV_STEP_W = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF3   = 3'd5;

  // Command codes.
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HASH_WAIT,
    S_RMW_READ,
    S_RMW_WRITE,
    S_READ,
    S_READ_DATA,
    S_DONE
  } cms_state_t;

  typedef enum logic [1:0] {
    H_IDLE,
    H_RED,
    H_DIV,
    H_DONE
  } hash_state_t;

  typedef struct packed {
    logic                  start;
    logic [KEY_W-1:0]      key;
    logic [COEF_W-1:0]     coef;
    logic [COLS_CFG_W-1:0] cols;
  } hash_req_t;

  typedef struct packed {
    logic             done;
    logic [COL_W-1:0] column;
  } hash_rsp_t;

endpackage

[rtl/core/cms_in_if.sv]
interface cms_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [cms_pkg::KEY_W-1:0]      key;
  logic [cms_pkg::ROW_SEL_W-1:0]  row_select;
  logic [cms_pkg::COL_SEL_W-1:0]  column_select;

  modport source (output valid, command, key, row_select, column_select, input ready);
  modport sink (input valid, command, key, row_select, column_select, output ready);
endinterface

[rtl/core/cms_out_if.sv]
interface cms_out_if;
  logic                       valid;
  logic                       ready;
  logic [cms_pkg::CNT_W-1:0]  count_value;

  modport source (output valid, count_value, input ready);
  modport sink (input valid, count_value, output ready);
endinterface

[rtl/core/cms_ram.sv]
module cms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/cms_hash.sv]
module cms_column_hash (
  input  logic                clk,
  input  logic                rst,
  input  cms_pkg::hash_req_t  req,
  output cms_pkg::hash_rsp_t  rsp
);

  cms_pkg::hash_state_t hash_state, hash_state_next;

  logic [cms_pkg::KEY_W-1:0]      prod;
  logic [cms_pkg::KEY_W-1:0]      addend;
  logic [cms_pkg::COLS_CFG_W-1:0] divisor;
  logic [cms_pkg::KEY_W-1:0]      dvd;
  logic [cms_pkg::COL_W-1:0]      rem;
  logic [cms_pkg::COL_W-1:0]      rem_next;
  logic [cms_pkg::DIV_STEP_W-1:0] step;
  logic [cms_pkg::KEY_W-1:0]      prod_lo;
  logic [cms_pkg::KEY_W-1:0]      sum;
  logic [cms_pkg::KEY_W-1:0]      reduced;

  // Low half of the product only; the hash keeps the truncated value.
  assign prod_lo = req.coef[cms_pkg::COEF_W-1:cms_pkg::KEY_W] * req.key;
  assign sum     = prod + addend;
  assign reduced = (sum >= cms_pkg::HASH_PRIME) ? sum - cms_pkg::HASH_PRIME : sum;

  // Restoring remainder, DIV_BITS dividend bits per cycle, MSB first.
  always_comb begin
    logic [cms_pkg::COL_W:0]   t;
    logic [cms_pkg::COL_W-1:0] r;
    r = rem;
    t = '0;
    for (int i = 0; i < cms_pkg::DIV_BITS; i++) begin
      t = {r, dvd[cms_pkg::KEY_W-1-i]};
      if (t >= divisor[cms_pkg::COL_W:0]) begin
        t = t - divisor[cms_pkg::COL_W:0];
      end
      r = t[cms_pkg::COL_W-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_state <= cms_pkg::H_IDLE;
    end else begin
      hash_state <= hash_state_next;
    end
  end

  always_comb begin
    hash_state_next = hash_state;
    rsp.done        = 1'b0;
    rsp.column      = rem;
    case (hash_state)
      cms_pkg::H_IDLE: begin
        if (req.start) begin
          hash_state_next = cms_pkg::H_RED;
        end
      end
      cms_pkg::H_RED: begin
        hash_state_next = cms_pkg::H_DIV;
      end
      cms_pkg::H_DIV: begin
        if (step == cms_pkg::DIV_STEP_W'(cms_pkg::DIV_STEPS - 1)) begin
          hash_state_next = cms_pkg::H_DONE;
        end
      end
      cms_pkg::H_DONE: begin
        rsp.done        = 1'b1;
        hash_state_next = cms_pkg::H_IDLE;
      end
      default: begin
        hash_state_next = cms_pkg::H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (hash_state == cms_pkg::H_RED) begin
      step <= '0;
    end else if (hash_state == cms_pkg::H_DIV) begin
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (hash_state)
      cms_pkg::H_IDLE: begin
        if (req.start) begin
          prod    <= prod_lo;
          addend  <= req.coef[cms_pkg::KEY_W-1:0];
          divisor <= req.cols;
        end
      end
      cms_pkg::H_RED: begin
        dvd <= reduced;
        rem <= '0;
      end
      cms_pkg::H_DIV: begin
        dvd <= dvd << cms_pkg::DIV_BITS;
        rem <= rem_next;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/count_min_sketch_update.sv]
// An update runs each row in use through the shared hash and remainder unit (2-bit
// restoring remainder), then reads its counter and writes it back plus one on the
// counter memory's single port pair; a read command reads one counter. The next item
// can be taken as soon as the result is loaded into the output register.
// Reset is synchronous: after rst falls the block clears all 4096 counters, one a cycle,
// and accepts no item until the clear is done; configuration writes are taken throughout.
module count_min_sketch_update (
  input  logic                           clk,
  input  logic                           rst,
  cms_in_if.sink                         request,
  cms_out_if.source                      response,
  input  logic                           cfg_we,
  input  logic [cms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cms_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers, kept as written.
  logic [cms_pkg::COLS_CFG_W-1:0] cols_cfg;
  logic [cms_pkg::ROWS_CFG_W-1:0] rows_cfg;
  logic [cms_pkg::COEF_W-1:0]     coef [cms_pkg::MAX_ROWS];

  // Sequencer state and working registers.
  cms_pkg::cms_state_t state, state_next;
  logic [cms_pkg::ADDR_W-1:0]     clr_addr;
  logic [cms_pkg::ROW_W-1:0]      row;
  logic [cms_pkg::COL_W-1:0]      col_reg;
  logic [cms_pkg::KEY_W-1:0]      key_reg;
  logic                           cmd;
  logic [cms_pkg::ROW_SEL_W-1:0]  rsel;
  logic [cms_pkg::COL_SEL_W-1:0]  csel;
  logic [cms_pkg::CNT_W-1:0]      result;
  logic                           out_valid;
  logic [cms_pkg::CNT_W-1:0]      out_count;

  logic [cms_pkg::COLS_CFG_W-1:0] cols_eff;
  logic [cms_pkg::ROWS_CFG_W-1:0] rows_eff;
  logic                           last_row;
  logic                           in_range;
  logic                           out_free;
  logic [cms_pkg::CNT_W-1:0]      incremented;

  logic                           ram_we;
  logic [cms_pkg::ADDR_W-1:0]     ram_waddr;
  logic [cms_pkg::CNT_W-1:0]      ram_wdata;
  logic                           ram_re;
  logic [cms_pkg::ADDR_W-1:0]     ram_raddr;
  logic [cms_pkg::CNT_W-1:0]      ram_rdata;

  cms_pkg::hash_req_t hash_req;
  cms_pkg::hash_rsp_t hash_rsp;

  // A column count of zero acts as one column and counts past the table act as the
  // full width. Row counts are clamped the same way.
  assign cols_eff = (cols_cfg == '0) ? cms_pkg::COLS_CFG_W'(1) :
                    (cols_cfg > cms_pkg::COLS_CFG_W'(cms_pkg::MAX_COLUMNS)) ?
                    cms_pkg::COLS_CFG_W'(cms_pkg::MAX_COLUMNS) : cols_cfg;
  assign rows_eff = (rows_cfg == '0) ? cms_pkg::ROWS_CFG_W'(1) :
                    (rows_cfg > cms_pkg::ROWS_CFG_W'(cms_pkg::MAX_ROWS)) ?
                    cms_pkg::ROWS_CFG_W'(cms_pkg::MAX_ROWS) : rows_cfg;

  assign last_row    = cms_pkg::ROWS_CFG_W'(row) == rows_eff - 1'b1;
  assign in_range    = (32'(rsel) < cms_pkg::MAX_ROWS) && (32'(csel) < cms_pkg::MAX_COLUMNS);
  assign out_free    = !out_valid || response.ready;
  assign incremented = ram_rdata + cms_pkg::CNT_W'(1);

  assign request.ready        = (state == cms_pkg::S_IDLE);
  assign response.valid       = out_valid;
  assign response.count_value = out_count;

  // Configuration writes. Unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_cfg <= cms_pkg::COLS_CFG_W'(cms_pkg::MAX_COLUMNS);
      rows_cfg <= cms_pkg::ROWS_CFG_W'(cms_pkg::MAX_ROWS);
      for (int i = 0; i < cms_pkg::MAX_ROWS; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        cms_pkg::CFG_COLUMNS: cols_cfg <= cfg_data[cms_pkg::COLS_CFG_W-1:0];
        cms_pkg::CFG_ROWS:    rows_cfg <= cfg_data[cms_pkg::ROWS_CFG_W-1:0];
        cms_pkg::CFG_COEF0:   coef[0]  <= cfg_data;
        cms_pkg::CFG_COEF1:   coef[1]  <= cfg_data;
        cms_pkg::CFG_COEF2:   coef[2]  <= cfg_data;
        cms_pkg::CFG_COEF3:   coef[3]  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cms_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: per row of an update, hash, read the counter, write it back plus one; a read command reads one counter.
  always_comb begin
    state_next     = state;
    hash_req.start = 1'b0;
    hash_req.key   = key_reg;
    hash_req.coef  = coef[row];
    hash_req.cols  = cols_eff;
    ram_we         = 1'b0;
    ram_waddr      = {row, col_reg};
    ram_wdata      = incremented;
    ram_re         = 1'b0;
    ram_raddr      = {row, col_reg};
    case (state)
      cms_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == cms_pkg::ADDR_W'(cms_pkg::DEPTH - 1)) begin
          state_next = cms_pkg::S_IDLE;
        end
      end
      cms_pkg::S_IDLE: begin
        if (request.valid) begin
          state_next = (request.command == cms_pkg::CMD_UPDATE) ?
                       cms_pkg::S_HASH : cms_pkg::S_READ;
        end
      end
      cms_pkg::S_HASH: begin
        hash_req.start = 1'b1;
        state_next     = cms_pkg::S_HASH_WAIT;
      end
      cms_pkg::S_HASH_WAIT: begin
        if (hash_rsp.done) begin
          state_next = cms_pkg::S_RMW_READ;
        end
      end
      cms_pkg::S_RMW_READ: begin
        ram_re     = 1'b1;
        state_next = cms_pkg::S_RMW_WRITE;
      end
      cms_pkg::S_RMW_WRITE: begin
        ram_we     = 1'b1;
        state_next = last_row ? cms_pkg::S_DONE : cms_pkg::S_HASH;
      end
      cms_pkg::S_READ: begin
        ram_re     = 1'b1;
        ram_raddr  = {rsel, csel};
        state_next = cms_pkg::S_READ_DATA;
      end
      cms_pkg::S_READ_DATA: begin
        state_next = cms_pkg::S_DONE;
      end
      cms_pkg::S_DONE: begin
        if (out_free) begin
          state_next = cms_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cms_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == cms_pkg::S_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // The output register lets a finished result wait while the next item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == cms_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == cms_pkg::S_DONE && out_free) begin
      out_count <= result;
    end
  end

  // Working registers. The running minimum starts at all ones.
  always_ff @(posedge clk) begin
    case (state)
      cms_pkg::S_IDLE: begin
        if (request.valid) begin
          cmd     <= request.command;
          key_reg <= request.key;
          rsel    <= request.row_select;
          csel    <= request.column_select;
          row     <= '0;
          result  <= '1;
        end
      end
      cms_pkg::S_HASH_WAIT: begin
        if (hash_rsp.done) begin
          col_reg <= hash_rsp.column;
        end
      end
      cms_pkg::S_RMW_WRITE: begin
        row <= row + 1'b1;
        if (incremented < result) begin
          result <= incremented;
        end
      end
      cms_pkg::S_READ_DATA: begin
        result <= (in_range && cmd == cms_pkg::CMD_READ) ? ram_rdata : '0;
      end
      default: begin
      end
    endcase
  end

  cms_column_hash u_hash (
    .clk (clk),
    .rst (rst),
    .req (hash_req),
    .rsp (hash_rsp)
  );

  cms_ram #(
    .WIDTH (cms_pkg::CNT_W),
    .DEPTH (cms_pkg::DEPTH)
  ) u_counters (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[rtl/core/cms_update_checker.sv]
`include "count_min_sketch_update_assert.svh"

module cms_update_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [cms_pkg::CNT_W-1:0] out_count
);

  // A stalled result holds its value.
  `CMS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_count))

  // One item at a time: the block stops taking items right after an acceptance.
  `CMS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // No result can appear in the cycle right after an acceptance.
  `CMS_ASSERT_NEXT(a_no_instant_result, clk, rst, in_valid && in_ready, !$rose(out_valid))

  // A new result is loaded exactly as the block returns to idle.
  `CMS_ASSERT_SAME(a_result_when_idle, clk, rst, $rose(out_valid), in_ready)

endmodule

bind count_min_sketch_update cms_update_checker u_cms_update_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (request.valid),
  .in_ready  (request.ready),
  .out_valid (response.valid),
  .out_ready (response.ready),
  .out_count (response.count_value)
);
